// ----- rtl/core/vr2d_pkg.sv -----
// Shared types, widths and constants for the 2-D vector rotator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package vr2d_pkg;

  // Micro-rotations requested and the cells actually built (table holds 24)
  localparam int ITERATIONS = 16;
  localparam int TABLE_LEN  = 24;
  localparam int NCELL      = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

  // Field widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 17;
  localparam int FRAC  = 16;

  // Datapath widths: coordinates Q.16 with headroom for the CORDIC gain,
  // angle accumulator at 2^32 units per turn
  localparam int XW  = 36;
  localparam int ZW  = 32;
  localparam int SHW = 5;

  // Gain compensation, round(0.6072529350 * 2^30)
  localparam int GAIN_W = 31;
  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;

  // Rounding: product has 46 fractional bits
  localparam int PROD_FRAC = 46;
  localparam int SPLIT     = 18;

  typedef logic signed [IN_W-1:0]  coord_in_t;
  typedef logic signed [OUT_W-1:0] coord_out_t;

  // What one stage of the chain hands to the next
  typedef struct packed {
    logic                 vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } stage_t;

  // Arctangent of 2^-i in 2^32 units per turn
  function automatic logic signed [ZW-1:0] atan_lut(input logic [SHW-1:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/vr2d_if.sv -----
// Valid/ready channel interfaces for the vector rotator: input vector and
// rotated result. Depends on vr2d_pkg for the coordinate types.
`timescale 1ns / 1ps

interface vr2d_in_if;
  import vr2d_pkg::*;

  logic      valid;
  logic      ready;
  coord_in_t x_in;
  coord_in_t y_in;
  coord_in_t angle;

  modport source (output valid, x_in, y_in, angle, input ready);
  modport sink   (input valid, x_in, y_in, angle, output ready);
endinterface

interface vr2d_out_if;
  import vr2d_pkg::*;

  logic       valid;
  logic       ready;
  coord_out_t x_out;
  coord_out_t y_out;

  modport source (output valid, x_out, y_out, input ready);
  modport sink   (input valid, x_out, y_out, output ready);
endinterface

// ----- rtl/core/vr2d_prerot.sv -----
// Quadrant pre-rotation: exact turn by a multiple of 90 degrees, leaving a
// residual angle in [-45, +45) degrees. Depends on vr2d_pkg.
`timescale 1ns / 1ps

module vr2d_prerot (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid,
  input  vr2d_pkg::coord_in_t x_in,
  input  vr2d_pkg::coord_in_t y_in,
  input  vr2d_pkg::coord_in_t angle,
  output vr2d_pkg::stage_t    q
);
  import vr2d_pkg::*;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  localparam logic [IN_W-1:0] EIGHTH = 16'd8192;

  logic [IN_W-1:0]       sh;
  logic [1:0]            quad;
  logic signed [13:0]    resid;
  logic signed [IN_W:0]  xe;
  logic signed [IN_W:0]  ye;
  logic signed [IN_W:0]  xr;
  logic signed [IN_W:0]  yr;

  // Shift angle by an eighth turn so the quadrant sits in the top two bits
  assign sh    = angle + EIGHTH;
  assign quad  = sh[15:14];
  assign resid = {~sh[13], sh[12:0]};

  assign xe = {x_in[IN_W-1], x_in};
  assign ye = {y_in[IN_W-1], y_in};

  // Exact quarter-turn rotation
  always_comb begin
    unique case (quad)
      QUAD_0: begin xr = xe;  yr = ye;  end
      QUAD_1: begin xr = -ye; yr = xe;  end
      QUAD_2: begin xr = -xe; yr = -ye; end
      QUAD_3: begin xr = ye;  yr = -xe; end
      default: begin xr = xe; yr = ye; end
    endcase
  end

  // Clear the valid flag under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= valid;
    end
  end

  // Scale coordinates to Q.16, residual angle to 2^32 units per turn
  always_ff @(posedge clk) begin
    if (en) begin
      q.x <= {{(XW-IN_W-1-FRAC){xr[IN_W]}}, xr, {FRAC{1'b0}}};
      q.y <= {{(XW-IN_W-1-FRAC){yr[IN_W]}}, yr, {FRAC{1'b0}}};
      q.z <= {{(ZW-14-16){resid[13]}}, resid, 16'd0};
    end
  end

endmodule

// ----- rtl/core/vr2d_cell.sv -----
// One CORDIC micro-rotation cell: shift-add step on x and y, angle update.
// Shift amount and arctangent come in as constant ports. Depends on vr2d_pkg.
`timescale 1ns / 1ps

module vr2d_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [vr2d_pkg::SHW-1:0]       shift,
  input  logic signed [vr2d_pkg::ZW-1:0] atan,
  input  vr2d_pkg::stage_t               d,
  output vr2d_pkg::stage_t               q
);
  import vr2d_pkg::*;

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 ccw;

  // Floor shifts of the opposite coordinate; turn toward zero residual
  assign dx  = d.y >>> shift;
  assign dy  = d.x >>> shift;
  assign ccw = ~d.z[ZW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q.vld <= d.vld;
    end
  end

  // Advance the micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        q.x <= d.x - dx;
        q.y <= d.y + dy;
        q.z <= d.z - atan;
      end else begin
        q.x <= d.x + dx;
        q.y <= d.y - dy;
        q.z <= d.z + atan;
      end
    end
  end

endmodule

// ----- rtl/core/vr2d_gain.sv -----
// Gain compensation and rounding: split multiply by the inverse CORDIC gain,
// then recombine, round half up and register the result. Depends on vr2d_pkg.
`timescale 1ns / 1ps

module vr2d_gain (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  vr2d_pkg::stage_t       d,
  output logic                   valid,
  output vr2d_pkg::coord_out_t   x_out,
  output vr2d_pkg::coord_out_t   y_out
);
  import vr2d_pkg::*;

  localparam int LO_W = SPLIT + 1 + GAIN_W;       // unsigned low part times gain
  localparam int HI_W = XW - SPLIT + GAIN_W;      // signed high part times gain
  localparam int PW   = XW + GAIN_W + 1;
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (PROD_FRAC - 1);

  logic                   vld1;
  logic signed [LO_W-1:0] gl;
  logic signed [HI_W-1:0] gh;
  logic signed [LO_W-1:0] xlo_op;
  logic signed [LO_W-1:0] ylo_op;
  logic signed [HI_W-1:0] xhi_op;
  logic signed [HI_W-1:0] yhi_op;
  logic signed [LO_W-1:0] xlo;
  logic signed [LO_W-1:0] ylo;
  logic signed [HI_W-1:0] xhi;
  logic signed [HI_W-1:0] yhi;
  logic signed [PW-1:0]   xsum;
  logic signed [PW-1:0]   ysum;

  assign gl = {{(LO_W-GAIN_W){1'b0}}, GAIN_Q30};
  assign gh = {{(HI_W-GAIN_W){1'b0}}, GAIN_Q30};

  // Operands: low bits taken unsigned, high bits signed
  assign xlo_op = {{(LO_W-SPLIT){1'b0}}, d.x[SPLIT-1:0]};
  assign ylo_op = {{(LO_W-SPLIT){1'b0}}, d.y[SPLIT-1:0]};
  assign xhi_op = {{(HI_W-XW+SPLIT){d.x[XW-1]}}, d.x[XW-1:SPLIT]};
  assign yhi_op = {{(HI_W-XW+SPLIT){d.y[XW-1]}}, d.y[XW-1:SPLIT]};

  // Recombine partial products and add the rounding half
  assign xsum = ({{(PW-HI_W){xhi[HI_W-1]}}, xhi} <<< SPLIT)
              + {{(PW-LO_W){1'b0}}, xlo} + RND;
  assign ysum = ({{(PW-HI_W){yhi[HI_W-1]}}, yhi} <<< SPLIT)
              + {{(PW-LO_W){1'b0}}, ylo} + RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1  <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      vld1  <= d.vld;
      valid <= vld1;
    end
  end

  // Multiply stage, then round stage
  always_ff @(posedge clk) begin
    if (en) begin
      xlo   <= xlo_op * gl;
      ylo   <= ylo_op * gl;
      xhi   <= xhi_op * gh;
      yhi   <= yhi_op * gh;
      x_out <= xsum[PROD_FRAC+OUT_W-1:PROD_FRAC];
      y_out <= ysum[PROD_FRAC+OUT_W-1:PROD_FRAC];
    end
  end

endmodule

// ----- rtl/core/vector_rotate_2d.sv -----
// Channel   Role    Payload
// vec       sink    x_in, y_in, angle (signed 16 bits each)
// rot       source  x_out, y_out (signed 17 bits each)
//
// Takes one vector per clock while rot is not stalled; a result passes through
// the pre-rotation register, one register per CORDIC cell, then the gain
// multiply and rounding registers.
// Synchronous reset clears the valid flags of every stage only.
// A result held at rot stalls the whole chain in lockstep; vec.ready drops
// only while the output register is full and not being taken.
// Depends on vr2d_pkg, vr2d_if, vr2d_prerot, vr2d_cell and vr2d_gain.
`timescale 1ns / 1ps

module vector_rotate_2d (
  input  logic      clk,
  input  logic      rst,
  vr2d_in_if.sink   vec,
  vr2d_out_if.source rot
);
  import vr2d_pkg::*;

  logic   adv;
  stage_t chain [NCELL+1];

  // Advance every stage when the output register is free or being taken
  assign adv       = ~rot.valid | rot.ready;
  assign vec.ready = adv;

  vr2d_prerot u_prerot (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .valid (vec.valid),
    .x_in  (vec.x_in),
    .y_in  (vec.y_in),
    .angle (vec.angle),
    .q     (chain[0])
  );

  // Row of micro-rotation cells
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    vr2d_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .shift (SHW'(i)),
      .atan  (atan_lut(SHW'(i))),
      .d     (chain[i]),
      .q     (chain[i+1])
    );
  end

  vr2d_gain u_gain (
    .clk   (clk),
    .rst   (rst),
    .en    (adv),
    .d     (chain[NCELL]),
    .valid (rot.valid),
    .x_out (rot.x_out),
    .y_out (rot.y_out)
  );

  // Input is refused only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !vec.ready |-> (rot.valid && !rot.ready))
    else $error("input stalled without a held result");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rot.valid)
    else $error("result valid after reset");

  // A stalled chain keeps its first stage
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rot.valid && !rot.ready) |=> $stable(chain[0].vld))
    else $error("pre-rotation stage moved during stall");

  // An accepted vector reaches the first stage
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (vec.valid && vec.ready) |=> chain[0].vld)
    else $error("accepted transaction lost at pre-rotation");

endmodule

// ----- bench/vector_rotate_2d_tb.sv -----
// Self-checking bench for vector_rotate_2d: streams vectors through the rotator,
// predicts each rotated result with its own CORDIC and compares at the output.
// Depends on vr2d_pkg, vr2d_if and the rotator RTL.
`timescale 1ns / 1ps

module vector_rotate_2d_tb;
  import vr2d_pkg::*;

  localparam int     NUM_RANDOM  = 500;
  localparam int     WATCHDOG    = 1000;
  localparam int     DRAIN_WAIT  = 40;
  localparam int     MAX_REPORTS = 10;
  localparam int     ATAN_LEN    = 24;
  localparam longint GAIN_Q30_L  = 64'sd652032874;

  // Quarter turn selected by the top two bits of the shifted angle
  typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quadrant_t;

  typedef struct {
    coord_in_t x;
    coord_in_t y;
    coord_in_t ang;
  } vec_item_t;

  typedef struct {
    coord_out_t x;
    coord_out_t y;
  } rot_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vr2d_in_if  vec_ch ();
  vr2d_out_if rot_ch ();

  vector_rotate_2d uut (
    .clk (clk),
    .rst (rst),
    .vec (vec_ch),
    .rot (rot_ch)
  );

  // Arctangent of 2^-i, 2^32 units per turn
  longint atan_turn [ATAN_LEN] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  vec_item_t pending_vecs [$];
  rot_item_t expected_rots [$];
  vec_item_t next_vec;
  rot_item_t want_rot;
  logic      vec_taken = 1'b0;
  int        burst_left = 1;
  int        gap_left = 0;
  int        error_count = 0;
  int        idle_cycles = 0;
  int        cycle_count = 0;
  int        stall_mode = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Rotate one vector: quarter-turn pre-rotation, shift-add cells, gain, rounding
  function automatic rot_item_t rotate_vector(vec_item_t v);
    logic [15:0] shifted;
    quadrant_t   quad;
    longint      px, py, pz, dx, dy, xr, yr;
    rot_item_t   r;
    shifted = v.ang + 16'd8192;
    quad    = quadrant_t'(shifted[15:14]);
    case (quad)
      QUAD_0: begin
        px = longint'(v.x);
        py = longint'(v.y);
      end
      QUAD_90: begin
        px = -longint'(v.y);
        py = longint'(v.x);
      end
      QUAD_180: begin
        px = -longint'(v.x);
        py = -longint'(v.y);
      end
      default: begin
        px = longint'(v.y);
        py = -longint'(v.x);
      end
    endcase
    px = px * 65536;
    py = py * 65536;
    pz = (longint'(shifted[13:0]) - 8192) * 65536;
    for (int i = 0; i < ITERATIONS && i < ATAN_LEN; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (pz >= 0) begin
        px = px - dx;
        py = py + dy;
        pz = pz - atan_turn[i];
      end else begin
        px = px + dx;
        py = py - dy;
        pz = pz + atan_turn[i];
      end
    end
    // Exact halves round toward +inf
    xr = (px * GAIN_Q30_L + (64'sd1 <<< 45)) >>> 46;
    yr = (py * GAIN_Q30_L + (64'sd1 <<< 45)) >>> 46;
    r.x = xr[OUT_W-1:0];
    r.y = yr[OUT_W-1:0];
    return r;
  endfunction

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  task automatic push_vec(int x, int y, int a);
    vec_item_t v;
    v.x   = x[15:0];
    v.y   = y[15:0];
    v.ang = a[15:0];
    pending_vecs.push_back(v);
  endtask

  // Mostly uniform, sometimes a corner value
  function automatic int pick_coord();
    int corners [5] = '{-32768, -1, 0, 1, 32767};
    if ($urandom_range(0, 4) == 0) begin
      return corners[$urandom_range(0, 4)];
    end
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Uniform, or on or beside an octant boundary
  function automatic int pick_angle();
    int kind;
    int octant;
    kind   = $urandom_range(0, 9);
    octant = int'($urandom_range(0, 7)) * 8192 - 32768;
    if (kind < 6) begin
      return int'($urandom_range(0, 65535)) - 32768;
    end else if (kind < 8) begin
      return octant + int'($urandom_range(0, 4)) - 2;
    end
    return octant;
  endfunction

  // Sample both channels on the rising edge: check results, predict new vectors
  always @(posedge clk) begin
    vec_taken <= !rst && vec_ch.valid && vec_ch.ready;
    if (!rst && rot_ch.valid && rot_ch.ready) begin
      if (expected_rots.size() == 0) begin
        note_error($sformatf("unexpected result x_out=%0d y_out=%0d",
                             rot_ch.x_out, rot_ch.y_out));
      end else begin
        want_rot = expected_rots.pop_front();
        if (want_rot.x !== rot_ch.x_out || want_rot.y !== rot_ch.y_out) begin
          note_error($sformatf("x_out exp %0d got %0d, y_out exp %0d got %0d",
                               want_rot.x, rot_ch.x_out, want_rot.y, rot_ch.y_out));
        end
      end
    end
    if (!rst && vec_ch.valid && vec_ch.ready) begin
      next_vec.x   = vec_ch.x_in;
      next_vec.y   = vec_ch.y_in;
      next_vec.ang = vec_ch.angle;
      expected_rots.push_back(rotate_vector(next_vec));
    end
  end

  // Present vectors in bursts with random gaps; hold each until taken
  always @(negedge clk) begin
    if (rst) begin
      vec_ch.valid <= 1'b0;
    end else if (!vec_ch.valid || vec_taken) begin
      if (gap_left > 0 || pending_vecs.size() == 0) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        vec_ch.valid <= 1'b0;
      end else begin
        next_vec = pending_vecs.pop_front();
        vec_ch.valid <= 1'b1;
        vec_ch.x_in  <= next_vec.x;
        vec_ch.y_in  <= next_vec.y;
        vec_ch.angle <= next_vec.ang;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Stall the result channel in one of four randomly redrawn patterns
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    if (rst) begin
      rot_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       rot_ch.ready <= 1'b1;
        1:       rot_ch.ready <= 1'($urandom_range(0, 1));
        2:       rot_ch.ready <= (cycle_count % 5 != 0);
        default: rot_ch.ready <= ((cycle_count / 16) % 2 == 0);
      endcase
    end
  end

  // End the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (vec_ch.valid && vec_ch.ready) || (rot_ch.valid && rot_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("** vector_rotate_2d: FAILED **");
      $finish;
    end
  end

  initial begin
    vec_ch.valid = 1'b0;
    vec_ch.x_in  = '0;
    vec_ch.y_in  = '0;
    vec_ch.angle = '0;
    rot_ch.ready = 1'b0;

    // Directed: corners, every quadrant, octant boundaries and their neighbours
    push_vec(32767, 0, 0);
    push_vec(-32768, -32768, 0);
    push_vec(-32768, -32768, 8192);
    push_vec(-32768, -32768, -8192);
    push_vec(32767, 32767, -8192);
    push_vec(32767, -32768, 16384);
    push_vec(-32768, 32767, -16384);
    push_vec(12345, -23456, -32768);
    push_vec(-32768, 0, 24576);
    push_vec(-32768, 0, -24576);
    push_vec(32767, 32767, 32767);
    push_vec(0, 0, 12345);
    push_vec(1, 0, 8191);
    push_vec(1, 0, 8193);
    push_vec(-1, -1, -8193);
    push_vec(100, -200, 1);
    push_vec(-32768, 32767, -1);
    push_vec(1000, 1000, -24576);
    push_vec(0, -32768, 4096);
    push_vec(-32768, 0, 5000);
    push_vec(3, 5, 7);
    push_vec(-1, 0, 16384);
    push_vec(1, 1, 21845);

    // Random vectors
    for (int n = 0; n < NUM_RANDOM; n++) begin
      push_vec(pick_coord(), pick_coord(), pick_angle());
    end

    // Hold reset, release on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Drain: everything sent and every result back, then let the pipe settle
    while (pending_vecs.size() != 0 || vec_ch.valid || expected_rots.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_WAIT) @(negedge clk);
    if (expected_rots.size() != 0) begin
      note_error($sformatf("%0d results never arrived", expected_rots.size()));
    end

    if (error_count == 0) begin
      $display("** vector_rotate_2d: PASSED **");
    end else begin
      $display("** vector_rotate_2d: FAILED **");
    end
    $finish;
  end

endmodule
